// ----- src/tqps_pkg.sv -----
// Package for the two-queue priority server.
// Holds the queue sizing constants, operation and register codes, and shared types.
// Depends on nothing.
package tqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int AGE_W       = 8;
    localparam int COUNT_W     = 5;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] STREAK_LIMIT_RESET  = 8'd1;
    localparam logic [CFG_W-1:0] AGE_THRESHOLD_RESET = 8'd60;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_SERVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- src/two_queue_priority_server_core.sv -----
// Top level of the two-queue priority server.
// Joins the controller tqps_ctrl and the datapath tqps_datapath; uses tqps_pkg.
//
// A transaction is accepted when i_start is high while o_busy is low, and runs as a
// capture step, a step that updates the queues and reads the head entry into its output
// register, and a result step in which the result is shown with o_done high.
// The result is valid for a single cycle only, since the receiver cannot stall,
// and o_busy stays high after acceptance until the result cycle ends, so a new
// transaction is accepted only once the previous one is done. Configuration writes
// are always ready and must only be issued while the block is idle.
module two_queue_priority_server_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_mode,
    input  logic [tqps_pkg::ID_W-1:0]        i_person_id,
    input  logic [tqps_pkg::AGE_W-1:0]       i_age,
    output logic                             o_done,
    output logic                             o_add_accepted,
    output logic                             o_served_valid,
    output logic                             o_served_priority,
    output logic [tqps_pkg::ID_W-1:0]        o_served_id,
    output logic [tqps_pkg::AGE_W-1:0]       o_served_age,
    output logic [tqps_pkg::COUNT_W-1:0]     o_priority_count,
    output logic [tqps_pkg::COUNT_W-1:0]     o_common_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tqps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tqps_pkg::CFG_W-1:0]       i_cfg_data
);
    import tqps_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    tqps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    tqps_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_mode),
        .i_person_id       (i_person_id),
        .i_age             (i_age),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_add_accepted    (o_add_accepted),
        .o_served_valid    (o_served_valid),
        .o_served_priority (o_served_priority),
        .o_served_id       (o_served_id),
        .o_served_age      (o_served_age),
        .o_priority_count  (o_priority_count),
        .o_common_count    (o_common_count)
    );

endmodule

// ----- src/tqps_ctrl.sv -----
// Controller state machine for the two-queue priority server.
// Sequences capture, queue update and result cycles; uses tqps_pkg.
module tqps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_done,
    output tqps_pkg::t_dp_cmd o_cmd
);
    import tqps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_busy     = 1'b1;
        o_done     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tqps_datapath.sv -----
// Datapath for the two-queue priority server: both queues, their pointers,
// the streak counter, the configuration registers and the result registers; uses tqps_pkg.
module tqps_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tqps_pkg::t_dp_cmd                i_cmd,
    input  logic                             i_mode,
    input  logic [tqps_pkg::ID_W-1:0]        i_person_id,
    input  logic [tqps_pkg::AGE_W-1:0]       i_age,
    input  logic                             i_cfg_we,
    input  logic [tqps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tqps_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_add_accepted,
    output logic                             o_served_valid,
    output logic                             o_served_priority,
    output logic [tqps_pkg::ID_W-1:0]        o_served_id,
    output logic [tqps_pkg::AGE_W-1:0]       o_served_age,
    output logic [tqps_pkg::COUNT_W-1:0]     o_priority_count,
    output logic [tqps_pkg::COUNT_W-1:0]     o_common_count
);
    import tqps_pkg::*;

    t_entry p_mem [QUEUE_DEPTH];
    t_entry c_mem [QUEUE_DEPTH];

    logic [CFG_W-1:0]  r_streak_limit;
    logic [CFG_W-1:0]  r_age_threshold;
    logic              r_mode;
    t_entry            r_in;
    logic [PTR_W-1:0]  r_p_head;
    logic [PTR_W-1:0]  r_c_head;
    logic [FILL_W-1:0] r_p_fill;
    logic [FILL_W-1:0] r_c_fill;
    logic [CFG_W-1:0]  r_streak;
    logic              r_add_acc;
    logic              r_srv_valid;
    logic              r_srv_pri;
    t_entry            r_rd;

    logic             p_has;
    logic             c_has;
    logic             to_pri;
    logic             push_p;
    logic             push_c;
    logic             pop_p;
    logic             pop_c;
    logic [PTR_W-1:0] p_tail;
    logic [PTR_W-1:0] c_tail;
    logic [PTR_W-1:0] p_head_inc;
    logic [PTR_W-1:0] c_head_inc;
    logic [PTR_W:0]   p_sum;
    logic [PTR_W:0]   c_sum;

    always_comb begin
        p_has  = (r_p_fill != '0);
        c_has  = (r_c_fill != '0);
        to_pri = (r_in.age > r_age_threshold);
        push_p = 1'b0;
        push_c = 1'b0;
        pop_p  = 1'b0;
        pop_c  = 1'b0;
        if (r_mode == MODE_ADD) begin
            if (to_pri) begin
                push_p = (r_p_fill < FILL_W'(QUEUE_DEPTH));
            end else begin
                push_c = (r_c_fill < FILL_W'(QUEUE_DEPTH));
            end
        end else begin
            if (p_has && c_has) begin
                pop_p = (r_streak < r_streak_limit);
                pop_c = !(r_streak < r_streak_limit);
            end else begin
                pop_p = p_has;
                pop_c = c_has;
            end
        end

        p_sum = {1'b0, r_p_head} + (PTR_W+1)'(r_p_fill);
        c_sum = {1'b0, r_c_head} + (PTR_W+1)'(r_c_fill);
        if (p_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            p_sum = p_sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        if (c_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            c_sum = c_sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        p_tail = p_sum[PTR_W-1:0];
        c_tail = c_sum[PTR_W-1:0];

        p_head_inc = (r_p_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_p_head + 1'b1;
        c_head_inc = (r_c_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_c_head + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_p) begin
            p_mem[p_tail] <= r_in;
        end
        if (i_cmd.exec && push_c) begin
            c_mem[c_tail] <= r_in;
        end
        if (i_cmd.exec) begin
            r_rd <= pop_p ? p_mem[r_p_head] : c_mem[r_c_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_in.id     <= i_person_id;
            r_in.age    <= i_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_limit  <= STREAK_LIMIT_RESET;
            r_age_threshold <= AGE_THRESHOLD_RESET;
            r_p_head        <= '0;
            r_c_head        <= '0;
            r_p_fill        <= '0;
            r_c_fill        <= '0;
            r_streak        <= '0;
            r_add_acc       <= 1'b0;
            r_srv_valid     <= 1'b0;
            r_srv_pri       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STREAK_LIMIT:  r_streak_limit  <= i_cfg_data;
                    CFG_AGE_THRESHOLD: r_age_threshold <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_add_acc   <= push_p || push_c;
                r_srv_valid <= pop_p || pop_c;
                r_srv_pri   <= pop_p;
                if (push_p) begin
                    r_p_fill <= r_p_fill + 1'b1;
                end
                if (push_c) begin
                    r_c_fill <= r_c_fill + 1'b1;
                end
                if (pop_p) begin
                    r_p_fill <= r_p_fill - 1'b1;
                    r_p_head <= p_head_inc;
                end
                if (pop_c) begin
                    r_c_fill <= r_c_fill - 1'b1;
                    r_c_head <= c_head_inc;
                end
                if (r_mode == MODE_SERVE) begin
                    if (pop_p && c_has) begin
                        r_streak <= r_streak + 1'b1;
                    end else begin
                        r_streak <= '0;
                    end
                end
            end
        end
    end

    assign o_add_accepted    = r_add_acc;
    assign o_served_valid    = r_srv_valid;
    assign o_served_priority = r_srv_pri;
    assign o_served_id       = r_srv_valid ? r_rd.id  : '0;
    assign o_served_age      = r_srv_valid ? r_rd.age : '0;
    assign o_priority_count  = COUNT_W'(r_p_fill);
    assign o_common_count    = COUNT_W'(r_c_fill);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_fill <= FILL_W'(QUEUE_DEPTH)) && (r_c_fill <= FILL_W'(QUEUE_DEPTH)))
        else $error("Queue fill count exceeds the queue depth.");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_add_acc && r_srv_valid))
        else $error("A transaction both stored and served an entry.");
    a_pri_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_srv_pri |-> r_srv_valid)
        else $error("Priority flag set without a served entry.");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && pop_p |=> r_p_fill == $past(r_p_fill) - 1'b1)
        else $error("Priority pop did not reduce the fill count by one.");
`endif

endmodule

// ----- tb/tb_two_queue_priority_server_core.sv -----
`timescale 1ns / 100ps
// Testbench for two_queue_priority_server_core: directed cases, then random add and serve traffic.
// A behavioral copy of both queues and the streak counter predicts each result.
// Depends on tqps_pkg and the core RTL.
module tb_two_queue_priority_server_core;
    import tqps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic               add_accepted;
        logic               served_valid;
        logic               served_priority;
        logic [ID_W-1:0]    served_id;
        logic [AGE_W-1:0]   served_age;
        logic [COUNT_W-1:0] priority_count;
        logic [COUNT_W-1:0] common_count;
    } t_outcome;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    logic                 i_mode      = MODE_ADD;
    logic [ID_W-1:0]      i_person_id = '0;
    logic [AGE_W-1:0]     i_age       = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_STREAK_LIMIT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    logic                 o_busy;
    logic                 o_done;
    logic                 o_add_accepted;
    logic                 o_served_valid;
    logic                 o_served_priority;
    logic [ID_W-1:0]      o_served_id;
    logic [AGE_W-1:0]     o_served_age;
    logic [COUNT_W-1:0]   o_priority_count;
    logic [COUNT_W-1:0]   o_common_count;
    logic                 o_cfg_ready;

    two_queue_priority_server_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_mode            (i_mode),
        .i_person_id       (i_person_id),
        .i_age             (i_age),
        .o_done            (o_done),
        .o_add_accepted    (o_add_accepted),
        .o_served_valid    (o_served_valid),
        .o_served_priority (o_served_priority),
        .o_served_id       (o_served_id),
        .o_served_age      (o_served_age),
        .o_priority_count  (o_priority_count),
        .o_common_count    (o_common_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    t_entry         prio_line [QUEUE_DEPTH];
    t_entry         common_line [QUEUE_DEPTH];
    int             prio_head     = 0;
    int             prio_fill     = 0;
    int             common_head   = 0;
    int             common_fill   = 0;
    logic [7:0]     streak        = '0;
    logic [CFG_W-1:0] streak_limit  = STREAK_LIMIT_RESET;
    logic [CFG_W-1:0] age_threshold = AGE_THRESHOLD_RESET;

    t_outcome       expected_outcomes [$];
    t_outcome       seen_outcome;
    t_outcome       want_outcome;
    int             error_count = 0;
    int             idle_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_outcome predict_outcome(input logic mode, input logic [ID_W-1:0] id,
                                                 input logic [AGE_W-1:0] age);
        t_outcome o;
        t_entry   e;
        logic     take_priority;
        o = '0;
        if (mode == MODE_ADD) begin
            if (age > age_threshold) begin
                if (prio_fill < QUEUE_DEPTH) begin
                    prio_line[(prio_head + prio_fill) % QUEUE_DEPTH] = {id, age};
                    prio_fill++;
                    o.add_accepted = 1'b1;
                end
            end else if (common_fill < QUEUE_DEPTH) begin
                common_line[(common_head + common_fill) % QUEUE_DEPTH] = {id, age};
                common_fill++;
                o.add_accepted = 1'b1;
            end
        end else begin
            if (prio_fill != 0 && common_fill != 0) begin
                take_priority = (streak < streak_limit);
                streak = take_priority ? streak + 8'd1 : 8'd0;
            end else begin
                take_priority = (prio_fill != 0);
                streak = '0;
            end
            if (take_priority) begin
                e = prio_line[prio_head];
                prio_head = (prio_head + 1) % QUEUE_DEPTH;
                prio_fill--;
                o.served_valid    = 1'b1;
                o.served_priority = 1'b1;
                o.served_id       = e.id;
                o.served_age      = e.age;
            end else if (common_fill != 0) begin
                e = common_line[common_head];
                common_head = (common_head + 1) % QUEUE_DEPTH;
                common_fill--;
                o.served_valid = 1'b1;
                o.served_id    = e.id;
                o.served_age   = e.age;
            end
        end
        o.priority_count = COUNT_W'(prio_fill);
        o.common_count   = COUNT_W'(common_fill);
        return o;
    endfunction

    function automatic string fmt_outcome(input t_outcome o);
        return $sformatf("acc=%0b valid=%0b prio=%0b id=%h age=%0d pcnt=%0d ccnt=%0d",
                         o.add_accepted, o.served_valid, o.served_priority, o.served_id,
                         o.served_age, o.priority_count, o.common_count);
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                                input logic [AGE_W-1:0] age);
        i_start     <= 1'b1;
        i_mode      <= mode;
        i_person_id <= id;
        i_age       <= age;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        expected_outcomes.push_back(predict_outcome(mode, id, age));
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_outcomes.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (index == CFG_STREAK_LIMIT) streak_limit = data;
        else age_threshold = data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] threshold);
        drain_results();
        write_register(CFG_STREAK_LIMIT, limit);
        write_register(CFG_AGE_THRESHOLD, threshold);
    endtask

    task automatic add_person(input logic [AGE_W-1:0] age);
        send_request(MODE_ADD, ID_W'($urandom_range(0, 65535)), age);
        pause(random_gap());
    endtask

    task automatic serve_next();
        send_request(MODE_SERVE, ID_W'($urandom_range(0, 65535)), AGE_W'($urandom_range(0, 255)));
        pause(random_gap());
    endtask

    task automatic test_reset_defaults();
        serve_next();
        send_request(MODE_ADD, 16'h0000, 8'd60);
        send_request(MODE_ADD, 16'hFFFF, 8'd61);
        pause(random_gap());
        add_person(8'd255);
        add_person(8'd0);
        repeat (5) serve_next();
    endtask

    task automatic test_limit_extremes();
        set_config(8'd0, 8'd0);
        add_person(8'd1);
        add_person(8'd0);
        serve_next();
        serve_next();
        set_config(8'd255, 8'd255);
        add_person(8'd255);
        add_person(8'd0);
        serve_next();
        serve_next();
    endtask

    task automatic test_full_queues();
        set_config(8'd1, 8'd60);
        repeat (QUEUE_DEPTH + 1) add_person(AGE_W'($urandom_range(61, 255)));
        repeat (QUEUE_DEPTH + 1) add_person(AGE_W'($urandom_range(0, 60)));
        repeat (2 * QUEUE_DEPTH + 1) serve_next();
    endtask

    task automatic test_limit_lowered();
        set_config(8'd4, 8'd60);
        repeat (4) add_person(AGE_W'($urandom_range(61, 255)));
        repeat (2) add_person(AGE_W'($urandom_range(0, 60)));
        repeat (3) serve_next();
        // The streak now exceeds the new limit, so the common queue goes next.
        set_config(8'd1, 8'd60);
        repeat (4) serve_next();
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] limit,
                                       input logic [CFG_W-1:0] threshold,
                                       input int count, input int add_pct, input bit gaps_on);
        int               r;
        logic [AGE_W-1:0] age;
        set_config(limit, threshold);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) age = threshold;
            else if (r < 30) age = threshold + 8'd1;
            else age = AGE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < add_pct) begin
                send_request(MODE_ADD, ID_W'($urandom_range(0, 65535)), age);
            end else begin
                send_request(MODE_SERVE, ID_W'($urandom_range(0, 65535)), age);
            end
            if (i == count / 2 || $urandom_range(0, 199) == 0) begin
                drain_results();
            end else if (gaps_on) begin
                pause(random_gap());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            seen_outcome = {o_add_accepted, o_served_valid, o_served_priority, o_served_id,
                            o_served_age, o_priority_count, o_common_count};
            if (expected_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result with no transaction pending: %s", fmt_outcome(seen_outcome));
            end else begin
                want_outcome = expected_outcomes.pop_front();
                if (seen_outcome !== want_outcome) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected %s", fmt_outcome(want_outcome));
                        $display("          actual   %s", fmt_outcome(seen_outcome));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_done === 1'b1
            || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_limit_extremes();
        test_full_queues();
        test_limit_lowered();
        test_random_traffic(8'd1, 8'd60, 200, 55, 1'b1);
        test_random_traffic(8'd0, 8'd0, 150, 60, 1'b1);
        test_random_traffic(8'd255, 8'd255, 150, 50, 1'b0);
        test_random_traffic(8'd2, 8'd128, 200, 65, 1'b1);
        test_random_traffic(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                            200, 50, 1'b1);
        test_random_traffic(8'd3, 8'd100, 150, 40, 1'b1);
        test_random_traffic(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 255)),
                            200, 55, 1'b0);
        test_random_traffic(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                            150, 70, 1'b1);
        drain_results();
        repeat (6) @(posedge i_clk);
        if (expected_outcomes.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
